// File: hw/rtl/vtrs_pkg.sv
// Shared types, widths, codes and reset values of the visible target rotation selector.
package vtrs_pkg;

  localparam int unsigned MaxTargetsDef = 16;
  localparam int unsigned ReqW          = 3;
  localparam int unsigned KeyW          = 32;
  localparam int unsigned ElevW         = 15;
  localparam int unsigned TimeW         = 32;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned EntryW        = KeyW + 1 + ElevW;

  localparam logic signed [ElevW-1:0] MinElevRst = 15'sd3000;
  localparam logic signed [ElevW-1:0] LowestElev = -15'sd9000;
  localparam logic [TimeW-1:0]        HoldRst    = 32'd6000;

  typedef enum logic [ReqW-1:0] {
    REQ_RESET  = 3'd0,
    REQ_CLEAR  = 3'd1,
    REQ_ADD    = 3'd2,
    REQ_UPDATE = 3'd3,
    REQ_NEXT   = 3'd4
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_ELEV = 1'b0,
    CFG_HOLD     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [KeyW-1:0]         key;
    logic                    visible;
    logic signed [ElevW-1:0] elev;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan_rd;
    logic decide;
    logic load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic fetch;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hw/rtl/vtrs_in_if.sv
// Request channel carrying one operation per transfer.
interface vtrs_in_if;
  import vtrs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ReqW-1:0]         req_type;
  logic [TimeW-1:0]        now_ms;
  logic [KeyW-1:0]         entry_key;
  logic                    entry_visible;
  logic signed [ElevW-1:0] entry_elevation;

  modport source (
    output valid, req_type, now_ms, entry_key, entry_visible, entry_elevation,
    input  ready
  );
  modport sink (
    input  valid, req_type, now_ms, entry_key, entry_visible, entry_elevation,
    output ready
  );
endinterface

// File: hw/rtl/vtrs_out_if.sv
// Result channel carrying the selection state after each operation.
interface vtrs_out_if #(
  parameter int unsigned SlotW = $clog2(vtrs_pkg::MaxTargetsDef) + 1,
  parameter int unsigned CntW  = $clog2(vtrs_pkg::MaxTargetsDef + 1)
);
  import vtrs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SlotW-1:0] selected_slot;
  logic [KeyW-1:0]         selected_key;
  logic signed [ElevW-1:0] selected_elevation;
  logic [CntW-1:0]         entry_count;
  logic                    add_accepted;

  modport source (
    output valid, selected_slot, selected_key, selected_elevation, entry_count, add_accepted,
    input  ready
  );
  modport sink (
    input  valid, selected_slot, selected_key, selected_elevation, entry_count, add_accepted,
    output ready
  );
endinterface

// File: hw/rtl/vtrs_cfg_if.sv
// Configuration write channel with register index and write data.
interface vtrs_cfg_if;
  import vtrs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/vtrs_ram.sv
// Generic single write port RAM with one registered read port.
module vtrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/vtrs_ctrl.sv
// Sequencing state machine that steps the datapath through one operation.
module vtrs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vtrs_pkg::dp_stat_t stat_i,
  output vtrs_pkg::dp_cmd_t  cmd_o
);
  import vtrs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_FLUSH  = 7'b0001000,
    S_DECIDE = 7'b0010000,
    S_LOAD   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.need_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = stat_i.fetch ? S_LOAD : S_DONE;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        cmd_o.out_load = stat_i.out_free;
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/vtrs_dp.sv
// Datapath: target table, selection registers, scan accumulators and result register.
module vtrs_dp #(
  parameter int unsigned MAX_TARGETS = vtrs_pkg::MaxTargetsDef,
  localparam int unsigned IdxW  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1,
  localparam int unsigned CntW  = $clog2(MAX_TARGETS + 1),
  localparam int unsigned SlotW = $clog2(MAX_TARGETS) + 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vtrs_pkg::dp_cmd_t                 cmd_i,
  output vtrs_pkg::dp_stat_t                stat_o,
  input  logic [vtrs_pkg::ReqW-1:0]         req_type_i,
  input  logic [vtrs_pkg::TimeW-1:0]        now_ms_i,
  input  logic [vtrs_pkg::KeyW-1:0]         entry_key_i,
  input  logic                              entry_visible_i,
  input  logic signed [vtrs_pkg::ElevW-1:0] entry_elevation_i,
  input  logic                              cfg_we_i,
  input  logic [vtrs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [vtrs_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [SlotW-1:0]           selected_slot_o,
  output logic [vtrs_pkg::KeyW-1:0]         selected_key_o,
  output logic signed [vtrs_pkg::ElevW-1:0] selected_elevation_o,
  output logic [CntW-1:0]                   entry_count_o,
  output logic                              add_accepted_o
);
  import vtrs_pkg::*;

  // Configuration and selection state.
  logic signed [ElevW-1:0] min_elev_q;
  logic [TimeW-1:0]        hold_q;
  logic [CntW-1:0]         fill_q;
  logic                    slot_vld_q;
  logic [IdxW-1:0]         slot_idx_q;
  logic [KeyW-1:0]         key_q;
  logic signed [ElevW-1:0] elev_q;
  logic [TimeW-1:0]        last_q;
  logic                    acc_q;

  // Latched request.
  logic [ReqW-1:0]  req_q;
  logic [TimeW-1:0] now_q;
  entry_t           new_q;

  // Scan pipeline and accumulators.
  logic [IdxW-1:0]         cnt_q;
  logic                    rd_vld_q;
  logic [IdxW-1:0]         rd_idx_q;
  logic                    m_vld_q, mav_vld_q, maq_vld_q, hi_vld_q, ha_vld_q, fv_vld_q, fq_vld_q;
  logic [IdxW-1:0]         m_idx_q, mav_idx_q, maq_idx_q, hi_idx_q, ha_idx_q, fv_idx_q, fq_idx_q;
  logic signed [ElevW-1:0] hi_elev_q;
  logic [IdxW-1:0]         fetch_idx_q;

  // Result register.
  logic                    out_valid_q;
  logic signed [SlotW-1:0] out_slot_q;
  logic [KeyW-1:0]         out_key_q;
  logic signed [ElevW-1:0] out_elev_q;
  logic [CntW-1:0]         out_cnt_q;
  logic                    out_acc_q;

  logic                    full;
  logic                    add_ok;
  logic [EntryW-1:0]       rd_data;
  entry_t                  rd_ent;
  logic [IdxW-1:0]         raddr;
  logic                    take_m, take_mav, take_maq, take_hi, take_ha, take_fv, take_fq;
  logic                    vis, qual;
  logic                    elapsed;
  logic                    dec_fetch, dec_clear, dec_set_last;
  logic [IdxW-1:0]         dec_idx;

  assign full   = (fill_q == CntW'(MAX_TARGETS));
  assign add_ok = cmd_i.exec && (req_q == REQ_ADD) && !full;
  assign raddr  = cmd_i.scan_rd ? cnt_q : dec_idx;
  assign rd_ent = rd_data;

  vtrs_ram #(
    .Width (EntryW),
    .Depth (MAX_TARGETS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (add_ok),
    .waddr_i (fill_q[IdxW-1:0]),
    .wdata_i (new_q),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  // Per-entry scan decisions.
  always_comb begin
    vis      = rd_ent.visible;
    qual     = vis && (rd_ent.elev >= min_elev_q);
    take_m   = rd_vld_q && !m_vld_q && (key_q != '0) && (rd_ent.key == key_q);
    take_mav = rd_vld_q && m_vld_q && vis && !mav_vld_q;
    take_maq = rd_vld_q && m_vld_q && qual && !maq_vld_q;
    take_hi  = rd_vld_q && vis && (rd_ent.elev > hi_elev_q);
    take_ha  = rd_vld_q && !take_hi && hi_vld_q && vis && !ha_vld_q;
    take_fv  = rd_vld_q && vis && !fv_vld_q;
    take_fq  = rd_vld_q && qual && !fq_vld_q;
  end

  // Selection decision once the scan has finished.
  always_comb begin
    dec_fetch    = 1'b0;
    dec_clear    = 1'b0;
    dec_set_last = 1'b0;
    dec_idx      = fetch_idx_q;
    elapsed      = ((now_q - last_q) >= hold_q);
    case (req_q)
      REQ_UPDATE: begin
        if (!m_vld_q) begin
          dec_set_last = 1'b1;
          dec_fetch    = hi_vld_q;
          dec_clear    = !hi_vld_q;
          dec_idx      = hi_idx_q;
        end else if (!elapsed) begin
          dec_fetch = 1'b1;
          dec_idx   = m_idx_q;
        end else begin
          dec_set_last = 1'b1;
          if (maq_vld_q) begin
            dec_fetch = 1'b1;
            dec_idx   = maq_idx_q;
          end else if (fq_vld_q) begin
            dec_fetch = 1'b1;
            dec_idx   = fq_idx_q;
          end else if (hi_vld_q) begin
            dec_fetch = 1'b1;
            dec_idx   = hi_idx_q;
          end else begin
            dec_clear = 1'b1;
          end
        end
      end
      REQ_NEXT: begin
        if (m_vld_q && mav_vld_q) begin
          dec_fetch = 1'b1;
          dec_idx   = mav_idx_q;
        end else if (!m_vld_q && hi_vld_q && ha_vld_q) begin
          dec_fetch = 1'b1;
          dec_idx   = ha_idx_q;
        end else if (fv_vld_q) begin
          dec_fetch = 1'b1;
          dec_idx   = fv_idx_q;
        end
        dec_set_last = dec_fetch;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o.need_scan = ((req_q == REQ_UPDATE) || (req_q == REQ_NEXT)) && (fill_q != '0);
    stat_o.scan_last = (CntW'(cnt_q) == (fill_q - CntW'(1)));
    stat_o.fetch     = dec_fetch;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_elev_q  <= MinElevRst;
      hold_q      <= HoldRst;
      fill_q      <= '0;
      slot_vld_q  <= 1'b0;
      key_q       <= '0;
      last_q      <= '0;
      acc_q       <= 1'b0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      m_vld_q     <= 1'b0;
      mav_vld_q   <= 1'b0;
      maq_vld_q   <= 1'b0;
      hi_vld_q    <= 1'b0;
      ha_vld_q    <= 1'b0;
      fv_vld_q    <= 1'b0;
      fq_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MIN_ELEV) begin
          min_elev_q <= cfg_data_i[ElevW-1:0];
        end else begin
          hold_q <= cfg_data_i[TimeW-1:0];
        end
      end
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.scan_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (take_m) begin
        m_vld_q <= 1'b1;
      end
      if (take_mav) begin
        mav_vld_q <= 1'b1;
      end
      if (take_maq) begin
        maq_vld_q <= 1'b1;
      end
      if (take_hi) begin
        hi_vld_q <= 1'b1;
        ha_vld_q <= 1'b0;
      end else if (take_ha) begin
        ha_vld_q <= 1'b1;
      end
      if (take_fv) begin
        fv_vld_q <= 1'b1;
      end
      if (take_fq) begin
        fq_vld_q <= 1'b1;
      end
      if (cmd_i.exec) begin
        cnt_q     <= '0;
        m_vld_q   <= 1'b0;
        mav_vld_q <= 1'b0;
        maq_vld_q <= 1'b0;
        hi_vld_q  <= 1'b0;
        ha_vld_q  <= 1'b0;
        fv_vld_q  <= 1'b0;
        fq_vld_q  <= 1'b0;
        acc_q     <= add_ok;
        case (req_q)
          REQ_RESET: begin
            fill_q     <= '0;
            slot_vld_q <= 1'b0;
            key_q      <= '0;
            last_q     <= '0;
          end
          REQ_CLEAR: begin
            fill_q     <= '0;
            slot_vld_q <= 1'b0;
          end
          REQ_ADD: begin
            if (!full) begin
              fill_q <= fill_q + 1'b1;
            end
          end
          REQ_UPDATE, REQ_NEXT: begin
            if (fill_q == '0) begin
              slot_vld_q <= 1'b0;
              key_q      <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.decide) begin
        if (dec_set_last) begin
          last_q <= now_q;
        end
        if (dec_clear) begin
          slot_vld_q <= 1'b0;
          key_q      <= '0;
        end
      end
      if (cmd_i.load) begin
        slot_vld_q <= 1'b1;
        key_q      <= rd_ent.key;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q         <= req_type_i;
      now_q         <= now_ms_i;
      new_q.key     <= entry_key_i;
      new_q.visible <= entry_visible_i;
      new_q.elev    <= entry_elevation_i;
    end
    rd_idx_q <= cnt_q;
    if (cmd_i.exec) begin
      hi_elev_q <= LowestElev;
    end
    if (take_m) begin
      m_idx_q <= rd_idx_q;
    end
    if (take_mav) begin
      mav_idx_q <= rd_idx_q;
    end
    if (take_maq) begin
      maq_idx_q <= rd_idx_q;
    end
    if (take_hi) begin
      hi_idx_q  <= rd_idx_q;
      hi_elev_q <= rd_ent.elev;
    end
    if (take_ha) begin
      ha_idx_q <= rd_idx_q;
    end
    if (take_fv) begin
      fv_idx_q <= rd_idx_q;
    end
    if (take_fq) begin
      fq_idx_q <= rd_idx_q;
    end
    if (cmd_i.decide) begin
      fetch_idx_q <= dec_idx;
    end
    if (cmd_i.load) begin
      slot_idx_q <= fetch_idx_q;
      elev_q     <= rd_ent.elev;
    end
    if (cmd_i.out_load) begin
      out_slot_q <= slot_vld_q ? SlotW'(slot_idx_q) : '1;
      out_key_q  <= slot_vld_q ? key_q : '0;
      out_elev_q <= slot_vld_q ? elev_q : '0;
      out_cnt_q  <= fill_q;
      out_acc_q  <= acc_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign selected_slot_o      = out_slot_q;
  assign selected_key_o       = out_key_q;
  assign selected_elevation_o = out_elev_q;
  assign entry_count_o        = out_cnt_q;
  assign add_accepted_o       = out_acc_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(MAX_TARGETS))
    else $error("table fill exceeds capacity");

  a_slot_in_table : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_vld_q |-> (CntW'(slot_idx_q) < fill_q))
    else $error("selected slot lies beyond the table fill");

  a_add_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_ok |=> (fill_q == $past(fill_q) + 1'b1) && acc_q)
    else $error("stored entry did not advance the table fill");

  a_scan_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> (CntW'(cnt_q) < fill_q))
    else $error("table scan read past the table fill");

endmodule

// File: hw/rtl/visible_target_rotation_selector.sv
// Top level of the visible target rotation selector: channels, controller and datapath.
//
//   Channel  Dir  Transfer content
//   req_i    in   req_type, now_ms, entry_key, entry_visible, entry_elevation
//   res_o    out  selected_slot, selected_key, selected_elevation, entry_count, add_accepted
//   cfg_i    in   index (0 min_elevation, 1 hold_interval_ms), data
//
// Full reset, clear, add and unknown requests pass through the exec and done states only.
// Update and manual next scan the table fill with one table read per cycle, then decide and,
// when an entry is fetched, load it; on an empty table they skip the scan.
// Reset brings the selection, fill and timer to zero and the registers to 3000 and 6000.
// The table needs no clearing pass, since only filled entries are ever read.
// A finished result waits in the output register while the next request is taken.
module visible_target_rotation_selector #(
  parameter int unsigned MAX_TARGETS = vtrs_pkg::MaxTargetsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vtrs_in_if.sink    req_i,
  vtrs_cfg_if.sink   cfg_i,
  vtrs_out_if.source res_o
);
  import vtrs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  vtrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vtrs_dp #(
    .MAX_TARGETS (MAX_TARGETS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .req_type_i           (req_i.req_type),
    .now_ms_i             (req_i.now_ms),
    .entry_key_i          (req_i.entry_key),
    .entry_visible_i      (req_i.entry_visible),
    .entry_elevation_i    (req_i.entry_elevation),
    .cfg_we_i             (cfg_i.valid),
    .cfg_index_i          (cfg_i.index),
    .cfg_data_i           (cfg_i.data),
    .out_ready_i          (res_o.ready),
    .out_valid_o          (res_o.valid),
    .selected_slot_o      (res_o.selected_slot),
    .selected_key_o       (res_o.selected_key),
    .selected_elevation_o (res_o.selected_elevation),
    .entry_count_o        (res_o.entry_count),
    .add_accepted_o       (res_o.add_accepted)
  );

endmodule

// File: tb/tb_visible_target_rotation_selector.sv
// Testbench for the visible target rotation selector: directed table, random sequences, predictor.
`timescale 1ns / 100ps

module tb_visible_target_rotation_selector;
  import vtrs_pkg::*;

  localparam int HalfPeriod     = 5;
  localparam int ResetCycles    = 7;
  localparam int NumPhases      = 6;
  localparam int ItemsPerPhase  = 240;
  localparam int DrainCycles    = 40;
  localparam int StallLimit     = 2000;
  localparam int NumDirected    = 23;

  localparam logic [ReqW-1:0] ReqSpare5 = 3'd5;
  localparam logic [ReqW-1:0] ReqSpare6 = 3'd6;
  localparam logic [ReqW-1:0] ReqSpare7 = 3'd7;

  typedef struct packed {
    logic [ReqW-1:0]         req;
    logic [TimeW-1:0]        now;
    logic [KeyW-1:0]         key;
    logic                    vis;
    logic signed [ElevW-1:0] elev;
  } request_t;

  typedef struct packed {
    logic signed [4:0]       slot;
    logic [KeyW-1:0]         key;
    logic signed [ElevW-1:0] elev;
    logic [4:0]              count;
    logic                    accepted;
  } selection_t;

  typedef struct packed {
    request_t   rq;
    logic       typed;
    selection_t exp;
  } directed_row_t;

  localparam selection_t NoSelection = '{-5'sd1, 32'd0, 15'sd0, 5'd0, 1'b0};

  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{'{REQ_UPDATE, 32'd0, 32'd0, 1'b0, 15'sd0}, 1'b1, NoSelection},
    '{'{REQ_NEXT, 32'd0, 32'd0, 1'b0, 15'sd0}, 1'b1, NoSelection},
    '{'{REQ_ADD, 32'd0, 32'hFFFF_FFFF, 1'b1, 15'sd9000}, 1'b1,
      '{-5'sd1, 32'd0, 15'sd0, 5'd1, 1'b1}},
    '{'{REQ_ADD, 32'd0, 32'd0, 1'b1, -15'sd9000}, 1'b1,
      '{-5'sd1, 32'd0, 15'sd0, 5'd2, 1'b1}},
    '{'{REQ_ADD, 32'd0, 32'd5, 1'b0, 15'sd4000}, 1'b0, '0},
    '{'{REQ_ADD, 32'd0, 32'd7, 1'b1, 15'sd2999}, 1'b0, '0},
    '{'{REQ_ADD, 32'd0, 32'd8, 1'b1, 15'sd3000}, 1'b0, '0},
    '{'{REQ_UPDATE, 32'd100, 32'd0, 1'b0, 15'sd0}, 1'b0, '0},
    '{'{REQ_UPDATE, 32'd6099, 32'd0, 1'b0, 15'sd0}, 1'b0, '0},
    '{'{REQ_UPDATE, 32'd6100, 32'd0, 1'b0, 15'sd0}, 1'b0, '0},
    '{'{REQ_NEXT, 32'd7000, 32'd0, 1'b0, 15'sd0}, 1'b0, '0},
    '{'{ReqSpare5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, -15'sd9000}, 1'b0, '0},
    '{'{ReqSpare6, 32'd0, 32'd0, 1'b0, 15'sd9000}, 1'b0, '0},
    '{'{ReqSpare7, 32'd12345, 32'd1, 1'b1, 15'sd0}, 1'b0, '0},
    '{'{REQ_CLEAR, 32'd0, 32'd0, 1'b0, 15'sd0}, 1'b1, NoSelection},
    '{'{REQ_ADD, 32'd0, 32'd9, 1'b1, 15'sd100}, 1'b0, '0},
    '{'{REQ_ADD, 32'd0, 32'hFFFF_FFFF, 1'b1, 15'sd50}, 1'b0, '0},
    '{'{REQ_UPDATE, 32'd7001, 32'd0, 1'b0, 15'sd0}, 1'b0, '0},
    '{'{REQ_UPDATE, 32'hFFFF_FFFF, 32'd0, 1'b0, 15'sd0}, 1'b0, '0},
    '{'{REQ_RESET, 32'd0, 32'd0, 1'b0, 15'sd0}, 1'b1, NoSelection},
    '{'{REQ_ADD, 32'd0, 32'd3, 1'b0, 15'sd0}, 1'b0, '0},
    '{'{REQ_NEXT, 32'd1, 32'd0, 1'b0, 15'sd0}, 1'b0, '0},
    '{'{REQ_UPDATE, 32'd2, 32'd0, 1'b0, 15'sd0}, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  vtrs_in_if  req_if ();
  vtrs_cfg_if cfg_if ();
  vtrs_out_if res_if ();

  visible_target_rotation_selector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Predicted block state.
  logic [KeyW-1:0]  tgt_key [MaxTargetsDef];
  logic             tgt_vis [MaxTargetsDef];
  int               tgt_elev [MaxTargetsDef];
  int               fill = 0;
  int               cur_slot = -1;
  logic [KeyW-1:0]  cur_key = '0;
  logic [TimeW-1:0] last_pick_ms = '0;
  int               min_elev_thr = int'(MinElevRst);
  logic [TimeW-1:0] hold_ms = HoldRst;

  selection_t       awaited_selections [$];
  logic [TimeW-1:0] now_cursor = '0;
  logic             steady = 1'b0;
  int unsigned      error_count = 0;
  int unsigned      quiet_cycles = 0;

  function automatic int slot_of_key();
    if (cur_key == '0) begin
      return -1;
    end
    for (int i = 0; i < fill; i++) begin
      if (tgt_key[i] == cur_key) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int highest_slot();
    int best;
    int best_elev;
    best = -1;
    best_elev = int'(LowestElev);
    for (int i = 0; i < fill; i++) begin
      if (tgt_vis[i] && tgt_elev[i] > best_elev) begin
        best_elev = tgt_elev[i];
        best = i;
      end
    end
    return best;
  endfunction

  function automatic int next_slot(int from, logic use_thr);
    int idx;
    for (int step = 1; step <= fill; step++) begin
      idx = (from + step) % fill;
      if (tgt_vis[idx] && (!use_thr || tgt_elev[idx] >= min_elev_thr)) begin
        return idx;
      end
    end
    return -1;
  endfunction

  function automatic void choose_slot(int idx);
    if (idx < 0 || idx >= fill) begin
      cur_slot = -1;
      cur_key = '0;
    end else begin
      cur_slot = idx;
      cur_key = tgt_key[idx];
    end
  endfunction

  function automatic selection_t selection_after(request_t rq);
    selection_t       r;
    int               found;
    int               nxt;
    logic [TimeW-1:0] held;
    r = '0;
    case (rq.req)
      REQ_RESET: begin
        fill = 0;
        cur_slot = -1;
        cur_key = '0;
        last_pick_ms = '0;
      end
      REQ_CLEAR: begin
        fill = 0;
        cur_slot = -1;
      end
      REQ_ADD: begin
        if (fill < int'(MaxTargetsDef)) begin
          tgt_key[fill] = rq.key;
          tgt_vis[fill] = rq.vis;
          tgt_elev[fill] = int'($signed(rq.elev));
          fill++;
          r.accepted = 1'b1;
        end
      end
      REQ_UPDATE: begin
        if (fill == 0) begin
          choose_slot(-1);
        end else begin
          cur_slot = slot_of_key();
          held = rq.now - last_pick_ms;
          if (cur_slot < 0) begin
            choose_slot(highest_slot());
            last_pick_ms = rq.now;
          end else if (held >= hold_ms) begin
            last_pick_ms = rq.now;
            nxt = next_slot(cur_slot, 1'b1);
            choose_slot(nxt >= 0 ? nxt : highest_slot());
          end
        end
      end
      REQ_NEXT: begin
        if (fill == 0) begin
          choose_slot(-1);
        end else begin
          found = slot_of_key();
          if (found < 0) begin
            found = highest_slot();
          end
          nxt = next_slot(found, 1'b0);
          if (nxt >= 0) begin
            choose_slot(nxt);
            last_pick_ms = rq.now;
          end
        end
      end
      default: ;
    endcase
    if (cur_slot >= 0 && cur_slot < fill) begin
      r.slot = 5'(cur_slot);
      r.key = tgt_key[cur_slot];
      r.elev = 15'(tgt_elev[cur_slot]);
    end else begin
      r.slot = -5'sd1;
    end
    r.count = 5'(fill);
    return r;
  endfunction

  function automatic request_t random_request();
    request_t         rq;
    int unsigned      pick;
    int               e;
    logic [TimeW-1:0] span;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      rq.req = REQ_ADD;
    end else if (pick < 70) begin
      rq.req = REQ_UPDATE;
    end else if (pick < 86) begin
      rq.req = REQ_NEXT;
    end else if (pick < 93) begin
      rq.req = REQ_CLEAR;
    end else if (pick < 96) begin
      rq.req = REQ_RESET;
    end else begin
      case ($urandom_range(0, 2))
        0: rq.req = ReqSpare5;
        1: rq.req = ReqSpare6;
        default: rq.req = ReqSpare7;
      endcase
    end

    case ($urandom_range(0, 9))
      0: rq.key = '0;
      1: rq.key = '1;
      2, 3, 4, 5, 6: rq.key = $urandom_range(1, 6);
      default: rq.key = $urandom();
    endcase
    rq.vis = ($urandom_range(0, 3) != 0);

    case ($urandom_range(0, 7))
      0: e = -9000;
      1: e = 9000;
      2: e = min_elev_thr;
      3: e = (min_elev_thr > -9000) ? min_elev_thr - 1 : -8999;
      4: e = -8999;
      default: e = int'($urandom_range(0, 18000)) - 9000;
    endcase
    rq.elev = 15'(e);

    span = (hold_ms < 10000) ? hold_ms / 2 + 1 : 32'd5000;
    case ($urandom_range(0, 9))
      0: now_cursor = $urandom();
      1: now_cursor = last_pick_ms + hold_ms;
      2: now_cursor = last_pick_ms + hold_ms - 1;
      3: ;
      default: now_cursor = now_cursor + $urandom_range(0, span);
    endcase
    rq.now = now_cursor;
    return rq;
  endfunction

  task automatic send_request(request_t rq, logic typed, selection_t typed_exp);
    int unsigned gap;
    selection_t  predicted;
    if ($urandom_range(0, 59) == 0) begin
      steady = ~steady;
    end
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.valid           <= 1'b1;
    req_if.req_type        <= rq.req;
    req_if.now_ms          <= rq.now;
    req_if.entry_key       <= rq.key;
    req_if.entry_visible   <= rq.vis;
    req_if.entry_elevation <= rq.elev;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = selection_after(rq);
    awaited_selections.push_back(typed ? typed_exp : predicted);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_MIN_ELEV) begin
      min_elev_thr = int'($signed(value[ElevW-1:0]));
    end else begin
      hold_ms = value;
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (awaited_selections.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  initial begin : receive
    int unsigned stall;
    selection_t  got;
    selection_t  want;
    res_if.ready = 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      got.slot     = res_if.selected_slot;
      got.key      = res_if.selected_key;
      got.elev     = res_if.selected_elevation;
      got.count    = res_if.entry_count;
      got.accepted = res_if.add_accepted;
      if (awaited_selections.size() == 0) begin
        $display("%0t: unexpected result transfer, slot %0d key %0h", $time,
                 $signed(got.slot), got.key);
        error_count++;
      end else begin
        want = awaited_selections.pop_front();
        check_field("selected_slot", longint'($signed(want.slot)),
                    longint'($signed(got.slot)));
        check_field("selected_key", longint'(want.key), longint'(got.key));
        check_field("selected_elevation", longint'($signed(want.elev)),
                    longint'($signed(got.elev)));
        check_field("entry_count", longint'(want.count), longint'(got.count));
        check_field("add_accepted", longint'(want.accepted), longint'(got.accepted));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("[visible_target_rotation_selector] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int               phase_min;
    logic [TimeW-1:0] phase_hold;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_RESET;
    req_if.now_ms = '0;
    req_if.entry_key = '0;
    req_if.entry_visible = 1'b0;
    req_if.entry_elevation = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_MIN_ELEV;
    cfg_if.data = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) begin
      send_request(DirectedRows[i].rq, DirectedRows[i].typed, DirectedRows[i].exp);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph)
        0: begin
          phase_min = -9000;
          phase_hold = '0;
        end
        1: begin
          phase_min = 9000;
          phase_hold = '1;
        end
        2: begin
          phase_min = int'($urandom_range(0, 18000)) - 9000;
          phase_hold = 32'd1;
        end
        3: begin
          phase_min = 0;
          phase_hold = HoldRst;
        end
        4: begin
          phase_min = int'($urandom_range(0, 6000)) - 3000;
          phase_hold = $urandom_range(50, 400);
        end
        default: begin
          phase_min = int'($urandom_range(0, 18000)) - 9000;
          phase_hold = $urandom();
        end
      endcase
      write_register(CFG_MIN_ELEV, CfgDataW'(phase_min));
      write_register(CFG_HOLD, phase_hold);
      if (ph % 2 == 1) begin
        now_cursor = 32'hFFFF_F000 + $urandom_range(0, 4095);
      end
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_request(random_request(), 1'b0, '0);
      end
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[visible_target_rotation_selector] OK");
    end else begin
      $display("[visible_target_rotation_selector] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/vtrs_pkg.sv
hw/rtl/vtrs_in_if.sv
hw/rtl/vtrs_out_if.sv
hw/rtl/vtrs_cfg_if.sv
hw/rtl/vtrs_ram.sv
hw/rtl/vtrs_ctrl.sv
hw/rtl/vtrs_dp.sv
hw/rtl/visible_target_rotation_selector.sv
tb/tb_visible_target_rotation_selector.sv
